@@ rtl/core/ede_pkg.sv @@
package ede_pkg;

    // Command codes
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_FEED   = 2'd2;
    localparam logic [1:0] CMD_FINISH = 2'd3;

    localparam int unsigned DIST_W = 16;
    localparam logic [DIST_W-1:0] DIST_SAT = {DIST_W{1'b1}};

    // One request on the input channel
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] symbol;
    } t_request;

    // One result on the output channel
    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } t_result;

    // Token handed from cell to cell along the chain
    typedef struct packed {
        logic              valid;
        logic [1:0]        cmd;
        logic [7:0]        symbol;
        logic [DIST_W-1:0] left_new;  // updated row entry of the left neighbor
        logic [DIST_W-1:0] left_old;  // row entry of the left neighbor before update
        logic [DIST_W-1:0] distance;  // distance picked up on a finish
        logic              overflow;
    } t_wave;

    // Increment with saturation
    function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] v);
        return (v == DIST_SAT) ? v : v + 1'b1;
    endfunction

    // Minimum of three
    function automatic logic [DIST_W-1:0] min3(input logic [DIST_W-1:0] a,
                                               input logic [DIST_W-1:0] b,
                                               input logic [DIST_W-1:0] c);
        logic [DIST_W-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

endpackage

@@ rtl/core/edit_distance_engine.sv @@
// Channel   | Ports                         | Handshake
// ----------+-------------------------------+-----------------------------------
// request   | start, busy, i_req            | taken when start high, busy low
// result    | o_valid, o_result             | one cycle per result, no stall
//
// Every request enters a chain of PATTERN_MAX cells, one per reference byte,
// and moves one cell per cycle; a request can be taken in every cycle.
// A finish reports its result when its token leaves the last cell of the chain.
// Reset (synchronous, active low) empties the reference and sets row entry j to j.
// busy stays low: the chain never holds off a request, and results cannot stall.
module edit_distance_engine #(
    parameter int PATTERN_MAX = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  ede_pkg::t_request i_req,
    output logic              busy,
    output logic              o_valid,
    output ede_pkg::t_result  o_result
);
    import ede_pkg::*;

    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam logic [LW-1:0] LEN_FULL = LW'(PATTERN_MAX);

    logic [LW-1:0]     r_len;
    logic [LW-1:0]     n_len;
    logic [DIST_W-1:0] r_count;
    logic [DIST_W-1:0] n_count;
    logic              r_ovf;
    logic              n_ovf;
    logic              w_accept;

    t_wave             w_wave [0:PATTERN_MAX];
    logic [LW-1:0]     w_len  [0:PATTERN_MAX];

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // Update length, compared count and overflow flag per command
    always_comb begin
        n_len   = r_len;
        n_count = r_count;
        n_ovf   = r_ovf;
        case (i_req.cmd)
            CMD_CLEAR: begin
                n_len   = '0;
                n_ovf   = 1'b0;
                n_count = '0;
            end
            CMD_APPEND: begin
                if (r_len < LEN_FULL) begin
                    n_len = r_len + 1'b1;
                end else begin
                    n_ovf = 1'b1;
                end
                n_count = '0;
            end
            CMD_FEED: begin
                n_count = sat_inc(r_count);
            end
            CMD_FINISH: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (w_accept) begin
            r_len   <= n_len;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    // Build the token for the first cell; column zero is the compared count
    always_comb begin
        w_wave[0].valid    = w_accept;
        w_wave[0].cmd      = i_req.cmd;
        w_wave[0].symbol   = i_req.symbol;
        w_wave[0].left_old = r_count;
        w_wave[0].left_new = sat_inc(r_count);
        w_wave[0].distance = r_count;
        w_wave[0].overflow = r_ovf;
        w_len[0]           = r_len;
    end

    // Row of cells
    for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
        ede_cell #(
            .CELL_IDX (g),
            .LEN_W    (LW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wave  (w_wave[g]),
            .i_len   (w_len[g]),
            .o_wave  (w_wave[g+1]),
            .o_len   (w_len[g+1])
        );
    end

    // Report finished requests from the end of the chain
    assign o_valid           = w_wave[PATTERN_MAX].valid
                               && (w_wave[PATTERN_MAX].cmd == CMD_FINISH);
    assign o_result.distance = w_wave[PATTERN_MAX].distance;
    assign o_result.overflow = w_wave[PATTERN_MAX].overflow;

`ifndef SYNTHESIS
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept && i_req.cmd == CMD_FINISH, PATTERN_MAX))
        else $error("result without a finish request PATTERN_MAX cycles earlier");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_FULL)
        else $error("reference length beyond PATTERN_MAX");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_len == LEN_FULL))
        else $error("overflow flag set with room left in the reference");

    a_finish_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.cmd == CMD_FINISH) |=> (r_count == '0))
        else $error("compared count not cleared after finish");
`endif

endmodule

@@ rtl/core/ede_cell.sv @@
module ede_cell #(
    parameter int CELL_IDX = 0,
    parameter int LEN_W    = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ede_pkg::t_wave     i_wave,
    input  logic [LEN_W-1:0]   i_len,
    output ede_pkg::t_wave     o_wave,
    output logic [LEN_W-1:0]   o_len
);
    import ede_pkg::*;

    localparam logic [LEN_W-1:0]  MY_IDX  = LEN_W'(CELL_IDX);
    localparam logic [LEN_W-1:0]  MY_LEN  = LEN_W'(CELL_IDX + 1);
    localparam logic [DIST_W-1:0] ROW_RST = DIST_W'(CELL_IDX + 1);

    logic [7:0]        r_ref;
    logic [DIST_W-1:0] r_row;
    logic [DIST_W-1:0] n_row;
    t_wave             r_wave;
    t_wave             n_wave;
    logic              r_valid;
    logic [LEN_W-1:0]  r_len;

    logic              w_active;
    logic [DIST_W-1:0] w_sub;
    logic [DIST_W-1:0] w_cand;

    // Compute the new row entry for a feed
    assign w_active = (i_len > MY_IDX);
    assign w_sub    = (i_wave.symbol != r_ref) ? sat_inc(i_wave.left_old) : i_wave.left_old;
    assign w_cand   = min3(sat_inc(i_wave.left_new), sat_inc(r_row), w_sub);

    // Apply the passing token to this cell
    always_comb begin
        n_row  = r_row;
        n_wave = i_wave;
        case (i_wave.cmd)
            CMD_CLEAR, CMD_APPEND: begin
                n_row = ROW_RST;
            end
            CMD_FEED: begin
                n_wave.left_old = r_row;
                n_wave.left_new = w_active ? w_cand : r_row;
                if (w_active) begin
                    n_row = w_cand;
                end
            end
            CMD_FINISH: begin
                if (i_len == MY_LEN) begin
                    n_wave.distance = r_row;
                end
                n_row = ROW_RST;
            end
            default: begin
                n_row = r_row;
            end
        endcase
        if (!i_wave.valid) begin
            n_row = r_row;
        end
    end

    // Hold the row entry and the token valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= ROW_RST;
            r_valid <= 1'b0;
        end else begin
            r_row   <= n_row;
            r_valid <= i_wave.valid;
        end
    end

    // Payload of the token and the stored reference byte
    always_ff @(posedge i_clk) begin
        r_wave <= n_wave;
        r_len  <= i_len;
        if (i_wave.valid && i_wave.cmd == CMD_APPEND && i_len == MY_IDX) begin
            r_ref <= i_wave.symbol;
        end
    end

    // Pass the token on
    always_comb begin
        o_wave       = r_wave;
        o_wave.valid = r_valid;
    end

    assign o_len = r_len;

endmodule

@@ bench/edit_distance_engine_check.sv @@
module edit_distance_engine_check #(
    parameter int PATTERN_MAX = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  ede_pkg::t_request i_req,
    input  logic              i_valid,
    input  ede_pkg::t_result  i_result,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ede_pkg::*;

    // Predicted state of the block
    logic [7:0]  ref_bytes [PATTERN_MAX];
    int          ref_len;
    logic [15:0] dist_row [PATTERN_MAX+1];
    logic [15:0] fed_count;
    logic        ovf_flag;

    // Distance reports still owed by the block, oldest first
    t_result     distance_reports [$];
    int          fail_total = 0;

    assign o_fail_count = fail_total;

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        fail_total++;
    endtask

    function automatic logic [15:0] bump(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // Reload row entry j with j and forget the compared string
    task automatic restart_row();
        for (int j = 0; j <= PATTERN_MAX; j++) begin
            dist_row[j] = 16'(j);
        end
        fed_count = '0;
    endtask

    // Advance the distance row by one compared byte
    task automatic absorb_symbol(input logic [7:0] sym);
        logic [15:0] diag;
        logic [15:0] up;
        logic [15:0] best;
        logic [16:0] sub;
        diag = dist_row[0];
        fed_count = bump(fed_count);
        dist_row[0] = fed_count;
        for (int j = 0; j < ref_len; j++) begin
            up = dist_row[j+1];
            sub = {1'b0, diag} + ((sym == ref_bytes[j]) ? 17'd0 : 17'd1);
            if (sub > 17'h0FFFF) begin
                sub = 17'h0FFFF;
            end
            best = bump(dist_row[j]);
            if (bump(up) < best) begin
                best = bump(up);
            end
            if (sub[15:0] < best) begin
                best = sub[15:0];
            end
            diag = up;
            dist_row[j+1] = best;
        end
    endtask

    task automatic apply_request(input t_request req);
        t_result res;
        case (req.cmd)
            CMD_CLEAR: begin
                ref_len = 0;
                ovf_flag = 1'b0;
                restart_row();
            end
            CMD_APPEND: begin
                if (ref_len < PATTERN_MAX) begin
                    ref_bytes[ref_len] = req.symbol;
                    ref_len++;
                end else begin
                    ovf_flag = 1'b1;
                end
                restart_row();
            end
            CMD_FEED: begin
                absorb_symbol(req.symbol);
            end
            default: begin
                res.distance = dist_row[ref_len];
                res.overflow = ovf_flag;
                distance_reports.push_back(res);
                restart_row();
            end
        endcase
    endtask

    // Check results first, then fold in the request taken at this edge
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            ref_len = 0;
            ovf_flag = 1'b0;
            restart_row();
            distance_reports.delete();
        end else begin
            if (i_valid === 1'b1) begin
                if (distance_reports.size() == 0) begin
                    report_mismatch($sformatf("unexpected result distance=%0d overflow=%0b",
                                              i_result.distance, i_result.overflow));
                end else begin
                    want = distance_reports.pop_front();
                    if (i_result.distance !== want.distance) begin
                        report_mismatch($sformatf("distance got %0d want %0d",
                                                  i_result.distance, want.distance));
                    end
                    if (i_result.overflow !== want.overflow) begin
                        report_mismatch($sformatf("overflow got %0b want %0b",
                                                  i_result.overflow, want.overflow));
                    end
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                apply_request(i_req);
            end
        end
        o_pending <= distance_reports.size();
    end

endmodule

@@ bench/edit_distance_engine_test.sv @@
module edit_distance_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ede_pkg::*;

    localparam int PATTERN_MAX = 32;
    localparam int RANDOM_REQUESTS = 1740;
    localparam int LONG_FEEDS = 96;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    t_request req = '0;
    logic     busy;
    logic     res_valid;
    t_result  res;
    int       fail_count;
    int       pending;

    int          idle_pct = 0;
    int          sent_total = 0;
    logic [7:0]  letters [4];
    logic [7:0]  ref_shadow [$];

    always #6 clk = ~clk;

    edit_distance_engine #(
        .PATTERN_MAX(PATTERN_MAX)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .start   (start),
        .i_req   (req),
        .busy    (busy),
        .o_valid (res_valid),
        .o_result(res)
    );

    edit_distance_engine_check #(
        .PATTERN_MAX(PATTERN_MAX)
    ) u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_req       (req),
        .i_valid     (res_valid),
        .i_result    (res),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Drop the run if it hangs
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Present one request, idling first at random, and hold until taken
    task automatic issue(input logic [1:0] cmd, input logic [7:0] sym);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req <= t_request'{cmd: cmd, symbol: sym};
        do @(posedge clk); while (busy !== 1'b0);
        sent_total++;
        if (cmd == CMD_CLEAR) begin
            ref_shadow.delete();
        end else if (cmd == CMD_APPEND && ref_shadow.size() < PATTERN_MAX) begin
            ref_shadow.push_back(sym);
        end
    endtask

    // Hold off until every owed distance report has come back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    function automatic logic [7:0] pick_symbol();
        if ($urandom_range(0, 9) == 0) begin
            return 8'($urandom);
        end
        return letters[$urandom_range(0, 3)];
    endfunction

    // One comparison session: clear (most times) and extend the reference, then one to three compared strings
    task automatic run_episode();
        int n;
        int rounds;
        logic [7:0] ref_now [$];
        for (int k = 0; k < 4; k++) begin
            letters[k] = 8'($urandom);
        end
        if ($urandom_range(0, 9) < 7) begin
            issue(CMD_CLEAR, 8'($urandom));
        end
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 8);
        for (int k = 0; k < n; k++) begin
            issue(CMD_APPEND, pick_symbol());
        end
        rounds = $urandom_range(1, 3);
        for (int r = 0; r < rounds; r++) begin
            if ($urandom_range(0, 2) == 0) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
                for (int k = 0; k < n; k++) begin
                    issue(CMD_FEED, pick_symbol());
                end
            end else begin
                // Edit a copy of the reference: skip, insert or substitute
                ref_now = ref_shadow;
                foreach (ref_now[j]) begin
                    case ($urandom_range(0, 9))
                        0: ;
                        1: begin
                            issue(CMD_FEED, pick_symbol());
                            issue(CMD_FEED, ref_now[j]);
                        end
                        2: issue(CMD_FEED, pick_symbol());
                        default: issue(CMD_FEED, ref_now[j]);
                    endcase
                end
            end
            issue(CMD_FINISH, 8'($urandom));
        end
    endtask

    initial begin
        int base;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty reference, extreme bytes, every command
        issue(CMD_FINISH, 8'h00);
        issue(CMD_FEED, 8'h00);
        issue(CMD_FEED, 8'hFF);
        issue(CMD_FINISH, 8'hFF);
        issue(CMD_APPEND, 8'h00);
        issue(CMD_APPEND, 8'hFF);
        issue(CMD_APPEND, 8'hA5);
        issue(CMD_FINISH, 8'h00);
        issue(CMD_FEED, 8'hFF);
        issue(CMD_FEED, 8'h00);
        issue(CMD_FEED, 8'hA5);
        issue(CMD_FINISH, 8'h00);
        issue(CMD_FEED, 8'h00);
        issue(CMD_FEED, 8'hFF);
        issue(CMD_FEED, 8'hA5);
        issue(CMD_FINISH, 8'h00);
        issue(CMD_CLEAR, 8'hFF);
        issue(CMD_FINISH, 8'h00);
        // An append in the middle of a comparison restarts the row
        issue(CMD_APPEND, 8'h5A);
        issue(CMD_FEED, 8'h5A);
        issue(CMD_APPEND, 8'h5A);
        issue(CMD_FINISH, 8'h00);
        drain();

        // Fill past capacity, then compare a string far longer than the reference
        issue(CMD_CLEAR, 8'h00);
        for (int k = 0; k < PATTERN_MAX + 2; k++) begin
            issue(CMD_APPEND, 8'($urandom));
        end
        issue(CMD_FINISH, 8'h00);
        for (int k = 0; k < 4; k++) begin
            letters[k] = 8'($urandom);
        end
        for (int k = 0; k < LONG_FEEDS; k++) begin
            issue(CMD_FEED, pick_symbol());
        end
        issue(CMD_FINISH, 8'h00);
        issue(CMD_FINISH, 8'h00);
        issue(CMD_CLEAR, 8'h00);
        issue(CMD_FINISH, 8'h00);

        // Random: mostly well-formed sessions, some raw noise
        base = sent_total;
        while (sent_total - base < RANDOM_REQUESTS) begin
            if (sent_total - base < RANDOM_REQUESTS / 3) begin
                idle_pct = 16;
            end else if (sent_total - base < 2 * RANDOM_REQUESTS / 3) begin
                if (idle_pct != 50) begin
                    drain();
                end
                idle_pct = 50;
            end else begin
                idle_pct = 0;
            end
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    issue(2'($urandom), 8'($urandom));
                end
            end else begin
                run_episode();
            end
        end

        start <= 1'b0;
        wait (pending == 0);
        repeat (PATTERN_MAX + 8) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/ede_pkg.sv
rtl/core/ede_cell.sv
rtl/core/edit_distance_engine.sv
bench/edit_distance_engine_check.sv
bench/edit_distance_engine_test.sv
